// File: sv/aps_pkg.sv
// shared types and constants of the associative page store
package aps_pkg;

    localparam int MAX_SLOTS      = 64;
    localparam int WORDS_PER_PAGE = 1024;

    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int WIDX_W    = 10;
    localparam int PAGE_AW   = SLOT_W + WIDX_W;
    localparam int PAGE_DEPTH = MAX_SLOTS * WORDS_PER_PAGE;
    localparam int ID_W      = 32;
    localparam int FORK_W    = 2;
    localparam int DATA_W    = 64;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_EXISTS = 2'd2,
        REQ_RESET  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG_RD,
        ST_TAG_CMP,
        ST_PAGE_RD,
        ST_PAGE_WR,
        ST_ALLOC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   space_id;
        logic [ID_W-1:0]   database_id;
        logic [ID_W-1:0]   rel_number;
        logic [FORK_W-1:0] fork_num;
        logic [ID_W-1:0]   block_number;
    } tag_t;

endpackage

// File: sv/aps_ram.sv
// generic simple dual port ram with registered read
module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/aps_tag_cmp.sv
// shared tag comparator, optionally ignoring the block number
module aps_tag_cmp (
    input  aps_pkg::tag_t stored,
    input  aps_pkg::tag_t key,
    input  logic          any_block,
    output logic          match
);

    logic rel_match;

    assign rel_match = (stored.space_id == key.space_id)
                    && (stored.database_id == key.database_id)
                    && (stored.rel_number == key.rel_number)
                    && (stored.fork_num == key.fork_num);

    assign match = rel_match && (any_block || (stored.block_number == key.block_number));

endmodule

// File: sv/assoc_page_store_unit.sv
// top level of the associative page store: sequencer, tag scan and page memory
//
// A request is accepted only while the block is idle; it then walks the used
// slots in order with one shared tag comparator, in a tag read and a compare
// state per slot because the tag memory has one registered read port, then
// goes through a page read, page write or allocation state if it needs one
// and ends in the finish state; a reset request goes straight to finish. The
// block takes the next request in the cycle after the result is loaded; the
// result sits in an output register, so that request is taken while it waits.
// Pages are not cleared on allocation, so there is no clearing pass after reset.
module assoc_page_store_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [6:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] space_id,
    input  logic [31:0] database_id,
    input  logic [31:0] rel_number,
    input  logic [1:0]  fork_req,
    input  logic [31:0] block_number,
    input  logic [9:0]  word_index,
    input  logic [63:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data,
    output logic        hit,
    output logic [5:0]  slot,
    output logic        status,
    output logic        warning,
    output logic [6:0]  used_count
);

    localparam int TAG_W = $bits(aps_pkg::tag_t);

    aps_pkg::state_t state_reg, state_next;

    logic [6:0]  warn_threshold_reg;
    logic [aps_pkg::COUNT_W-1:0] used_reg, used_next;
    logic [aps_pkg::SLOT_W-1:0]  idx_reg, idx_next;

    aps_pkg::req_t req_reg, req_next;
    aps_pkg::tag_t key_reg, key_next;
    logic [aps_pkg::WIDX_W-1:0]  widx_reg, widx_next;
    logic [aps_pkg::DATA_W-1:0]  wdata_reg, wdata_next;

    logic                        res_hit_reg, res_hit_next;
    logic [aps_pkg::SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic                        res_status_reg, res_status_next;
    logic                        res_warn_reg, res_warn_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] read_data_reg, read_data_next;
    logic        hit_reg, hit_next;
    logic [5:0]  slot_reg, slot_next;
    logic        status_reg, status_next;
    logic        warning_reg, warning_next;
    logic [6:0]  used_count_reg, used_count_next;

    logic accept;
    logic out_load;
    logic match;
    logic last_slot;
    logic store_full;

    logic                         tag_we;
    logic                         tag_re;
    aps_pkg::tag_t                tag_rdata;
    logic [TAG_W-1:0]             tag_rdata_bits;
    logic [aps_pkg::SLOT_W-1:0]   tag_waddr;

    logic                         page_we;
    logic                         page_re;
    logic [aps_pkg::PAGE_AW-1:0]  page_waddr;
    logic [aps_pkg::PAGE_AW-1:0]  page_raddr;
    logic [aps_pkg::DATA_W-1:0]   page_rdata;

    assign accept     = in_valid && in_ready;
    assign out_load   = !out_valid_reg || out_ready;
    assign last_slot  = ({1'b0, idx_reg} + 7'd1) == used_reg;
    assign store_full = used_reg == aps_pkg::COUNT_W'(aps_pkg::MAX_SLOTS);
    assign tag_rdata  = aps_pkg::tag_t'(tag_rdata_bits);

    aps_ram #(
        .WIDTH (TAG_W),
        .DEPTH (aps_pkg::MAX_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (TAG_W'(key_reg)),
        .re    (tag_re),
        .raddr (idx_reg),
        .rdata (tag_rdata_bits)
    );

    aps_ram #(
        .WIDTH (aps_pkg::DATA_W),
        .DEPTH (aps_pkg::PAGE_DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (wdata_reg),
        .re    (page_re),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    aps_tag_cmp u_tag_cmp (
        .stored    (tag_rdata),
        .key       (key_reg),
        .any_block (req_reg == aps_pkg::REQ_EXISTS),
        .match     (match)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (aps_pkg::req_t'(req_type) == aps_pkg::REQ_RESET)
                        state_next = aps_pkg::ST_FINISH;
                    else if (used_reg != '0)
                        state_next = aps_pkg::ST_TAG_RD;
                    else if (aps_pkg::req_t'(req_type) == aps_pkg::REQ_WRITE)
                        state_next = aps_pkg::ST_ALLOC;
                    else
                        state_next = aps_pkg::ST_FINISH;
                end
            end
            aps_pkg::ST_TAG_RD:
                state_next = aps_pkg::ST_TAG_CMP;
            aps_pkg::ST_TAG_CMP:
            begin
                priority if (match)
                begin
                    unique case (req_reg)
                        aps_pkg::REQ_READ:  state_next = aps_pkg::ST_PAGE_RD;
                        aps_pkg::REQ_WRITE: state_next = aps_pkg::ST_PAGE_WR;
                        default:            state_next = aps_pkg::ST_FINISH;
                    endcase
                end
                else if (!last_slot)
                    state_next = aps_pkg::ST_TAG_RD;
                else if (req_reg == aps_pkg::REQ_WRITE && !store_full)
                    state_next = aps_pkg::ST_ALLOC;
                else
                    state_next = aps_pkg::ST_FINISH;
            end
            aps_pkg::ST_PAGE_RD,
            aps_pkg::ST_PAGE_WR,
            aps_pkg::ST_ALLOC:
                state_next = aps_pkg::ST_FINISH;
            aps_pkg::ST_FINISH:
            begin
                if (out_load)
                    state_next = aps_pkg::ST_IDLE;
            end
            default:
                state_next = aps_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready        = 1'b0;
        tag_we          = 1'b0;
        tag_re          = 1'b0;
        tag_waddr       = used_reg[aps_pkg::SLOT_W-1:0];
        page_we         = 1'b0;
        page_re         = 1'b0;
        page_waddr      = {res_slot_reg, widx_reg};
        page_raddr      = {res_slot_reg, widx_reg};

        used_next       = used_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        widx_next       = widx_reg;
        wdata_next      = wdata_reg;
        res_hit_next    = res_hit_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        res_warn_next   = res_warn_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        read_data_next  = read_data_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        warning_next    = warning_reg;
        used_count_next = used_count_reg;

        unique case (state_reg)
            aps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    req_next                 = aps_pkg::req_t'(req_type);
                    key_next.space_id        = space_id;
                    key_next.database_id     = database_id;
                    key_next.rel_number      = rel_number;
                    key_next.fork_num        = fork_req;
                    key_next.block_number    = block_number;
                    widx_next                = word_index;
                    wdata_next               = write_data;
                    idx_next                 = '0;
                    res_hit_next             = 1'b0;
                    res_slot_next            = '0;
                    res_status_next          = 1'b0;
                    res_warn_next            = 1'b0;
                    if (aps_pkg::req_t'(req_type) == aps_pkg::REQ_RESET)
                        used_next = '0;
                end
            end
            aps_pkg::ST_TAG_RD:
                tag_re = 1'b1;
            aps_pkg::ST_TAG_CMP:
            begin
                priority if (match)
                begin
                    res_hit_next  = 1'b1;
                    res_slot_next = idx_reg;
                end
                else if (!last_slot)
                    idx_next = idx_reg + 1'b1;
                else if (req_reg == aps_pkg::REQ_WRITE && store_full)
                    res_status_next = 1'b1;
                else
                    idx_next = idx_reg;
            end
            aps_pkg::ST_PAGE_RD:
                page_re = 1'b1;
            aps_pkg::ST_PAGE_WR:
                page_we = 1'b1;
            aps_pkg::ST_ALLOC:
            begin
                // new slot at the fill count: tag and the requested word are written in the same cycle
                tag_we        = 1'b1;
                page_we       = 1'b1;
                page_waddr    = {used_reg[aps_pkg::SLOT_W-1:0], widx_reg};
                res_slot_next = used_reg[aps_pkg::SLOT_W-1:0];
                res_warn_next = used_reg >= warn_threshold_reg;
                used_next     = used_reg + 1'b1;
            end
            aps_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    read_data_next  = (req_reg == aps_pkg::REQ_READ && res_hit_reg)
                                      ? page_rdata : '0;
                    hit_next        = res_hit_reg;
                    slot_next       = res_slot_reg;
                    status_next     = res_status_reg;
                    warning_next    = res_warn_reg;
                    used_count_next = used_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= aps_pkg::ST_IDLE;
            warn_threshold_reg <= 7'd32;
            used_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                warn_threshold_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        req_reg        <= req_next;
        key_reg        <= key_next;
        widx_reg       <= widx_next;
        wdata_reg      <= wdata_next;
        res_hit_reg    <= res_hit_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        res_warn_reg   <= res_warn_next;
        read_data_reg  <= read_data_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        warning_reg    <= warning_next;
        used_count_reg <= used_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign hit        = hit_reg;
    assign slot       = slot_reg;
    assign status     = status_reg;
    assign warning    = warning_reg;
    assign used_count = used_count_reg;

endmodule
